### rtl/core/assert_macros.svh
// Assertion helpers shared by the core files.
// Every check is clocked on clk and held off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every clock edge.
`define ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/sha1md_pkg.sv
package sha1md_pkg;

  // Block geometry.
  localparam int unsigned WordW     = 32;
  localparam int unsigned BlockWords = 16;
  localparam int unsigned BlockBits = WordW * BlockWords;
  localparam int unsigned DigestWords = 5;
  localparam int unsigned Rounds    = 80;

  // Padding constants.
  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [5:0] LenPos  = 6'd56;

  typedef logic [WordW-1:0] word_t;
  typedef word_t digest_t [DigestWords];

  // Initial chaining value.
  localparam digest_t HInit = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  // Round constants, one for each group of twenty rounds.
  localparam word_t K0 = 32'h5A827999;
  localparam word_t K1 = 32'h6ED9EBA1;
  localparam word_t K2 = 32'h8F1BBCDC;
  localparam word_t K3 = 32'hCA62C1D6;

  // Working variables of the compression.
  typedef struct packed {
    word_t a;
    word_t b;
    word_t c;
    word_t d;
    word_t e;
  } work_t;

  // Control from the sequencer to the block window.
  typedef struct packed {
    logic       byte_en;
    logic [7:0] byte_val;
    logic       word_en;
  } win_ctl_t;

  function automatic word_t rotl1(input word_t v);
    return {v[WordW-2:0], v[WordW-1]};
  endfunction

  function automatic word_t rotl5(input word_t v);
    return {v[WordW-6:0], v[WordW-1:WordW-5]};
  endfunction

  function automatic word_t rotl30(input word_t v);
    return {v[1:0], v[WordW-1:2]};
  endfunction

endpackage

### rtl/core/sha1md_window.sv
module sha1md_window
  import sha1md_pkg::*;
(
  input  logic     clk,
  input  win_ctl_t ctl,
  output word_t    w_cur
);

  logic [BlockBits-1:0] win_r;
  word_t                w_new;

  // Word i of the window sits at the top end for i = 0.
  function automatic word_t word_at(input logic [BlockBits-1:0] v, input int unsigned i);
    return v[BlockBits-1-WordW*i -: WordW];
  endfunction

  // Next schedule word, sixteen rounds ahead of the current one.
  assign w_new = rotl1(word_at(win_r, 13) ^ word_at(win_r, 8) ^
                       word_at(win_r, 2) ^ word_at(win_r, 0));
  assign w_cur = word_at(win_r, 0);

  // Bytes shift in during gathering; words shift through during the rounds.
  always_ff @(posedge clk) begin
    if (ctl.byte_en) begin
      win_r <= {win_r[BlockBits-9:0], ctl.byte_val};
    end else if (ctl.word_en) begin
      win_r <= {win_r[BlockBits-WordW-1:0], w_new};
    end
  end

endmodule

### rtl/core/sha1md_round.sv
module sha1md_round
  import sha1md_pkg::*;
(
  input  work_t      wk,
  input  word_t      w,
  input  logic [6:0] rnd,
  output work_t      wk_next
);

  word_t f;
  word_t k;
  word_t t;

  // Round function and constant chosen by the group of twenty rounds.
  always_comb begin
    if (rnd < 7'd20) begin
      f = (wk.b & wk.c) | (~wk.b & wk.d);
      k = K0;
    end else if (rnd < 7'd40) begin
      f = wk.b ^ wk.c ^ wk.d;
      k = K1;
    end else if (rnd < 7'd60) begin
      f = (wk.b & wk.c) | (wk.b & wk.d) | (wk.c & wk.d);
      k = K2;
    end else begin
      f = wk.b ^ wk.c ^ wk.d;
      k = K3;
    end
  end

  assign t = rotl5(wk.a) + f + wk.e + k + w;

  // Rotate the working variables.
  assign wk_next = '{a: t, b: wk.a, c: rotl30(wk.b), d: wk.c, e: wk.d};

endmodule

### rtl/core/sha1_message_digest.sv
// SHA-1 digest of a byte stream, at most one byte per input transfer.
// A byte is taken whenever in_stall is low; a byte that fills a block stalls the input
// through all the rounds of the shared round unit, then the chain add.
// End of message: the input stalls while padding fills one or two blocks, each compressed, then 5 output transfers.
// No new bytes are taken while a 64-byte block is compressed by the single round unit.
// Reset is synchronous and active low: initial hash words, zero bit count and fill.
`include "assert_macros.svh"

module sha1_message_digest
  import sha1md_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_byte_present,
  input  logic        in_end_of_message,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PAD  = 3'd1;
  localparam logic [2:0] ST_RND  = 3'd2;
  localparam logic [2:0] ST_ADD  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  localparam logic [6:0] RndLast = 7'(Rounds - 1);
  localparam logic [2:0] IdxLast = 3'(DigestWords - 1);
  localparam logic [5:0] FillMax = 6'd63;

  logic [2:0]  state_r, state_nxt;
  logic [5:0]  fill_r, fill_nxt;
  logic [63:0] bits_r, bits_nxt;
  logic        fin_r, fin_nxt;
  logic        seen80_r, seen80_nxt;
  logic        lenblk_r, lenblk_nxt;
  logic [6:0]  rnd_r, rnd_nxt;
  logic [2:0]  idx_r, idx_nxt;
  work_t       wk_r, wk_nxt;
  digest_t     h_r, h_nxt;

  win_ctl_t    win_ctl;
  word_t       w_cur;
  work_t       wk_round;
  logic        in_xfer;
  logic        out_xfer;

  sha1md_window u_window (
    .clk   (clk),
    .ctl   (win_ctl),
    .w_cur (w_cur)
  );

  sha1md_round u_round (
    .wk      (wk_r),
    .w       (w_cur),
    .rnd     (rnd_r),
    .wk_next (wk_round)
  );

  // Handshake and result port.
  assign in_stall        = (state_r != ST_IDLE);
  assign in_xfer         = in_valid && !in_stall;
  assign out_valid       = (state_r == ST_OUT);
  assign out_xfer        = out_valid && !out_stall;
  assign out_digest_word = h_r[idx_r];
  assign out_word_index  = idx_r;
  assign out_last_word   = (idx_r == IdxLast);

  // Sequencer.
  always_comb begin
    state_nxt  = state_r;
    fill_nxt   = fill_r;
    bits_nxt   = bits_r;
    fin_nxt    = fin_r;
    seen80_nxt = seen80_r;
    lenblk_nxt = lenblk_r;
    rnd_nxt    = rnd_r;
    idx_nxt    = idx_r;
    wk_nxt     = wk_r;
    h_nxt      = h_r;
    win_ctl    = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          seen80_nxt = 1'b0;
          fin_nxt    = in_end_of_message;
          if (in_byte_present) begin
            win_ctl.byte_en  = 1'b1;
            win_ctl.byte_val = in_data_byte;
            fill_nxt         = fill_r + 6'd1;
            bits_nxt         = bits_r + 64'd8;
            if (fill_r == FillMax) begin
              state_nxt = ST_RND;
              wk_nxt    = '{a: h_r[0], b: h_r[1], c: h_r[2], d: h_r[3], e: h_r[4]};
            end else if (in_end_of_message) begin
              state_nxt = ST_PAD;
            end
          end else if (in_end_of_message) begin
            state_nxt = ST_PAD;
          end
        end
      end

      ST_PAD: begin
        // The marker byte, then zeros, then the bit count in the last block.
        win_ctl.byte_en = 1'b1;
        if (!seen80_r) begin
          win_ctl.byte_val = PadByte;
          seen80_nxt       = 1'b1;
          lenblk_nxt       = (fill_r < LenPos);
        end else if (lenblk_r && (fill_r >= LenPos)) begin
          win_ctl.byte_val = bits_r[63:56];
          bits_nxt         = {bits_r[55:0], bits_r[63:56]};
        end else begin
          win_ctl.byte_val = 8'h00;
        end
        fill_nxt = fill_r + 6'd1;
        if (fill_r == FillMax) begin
          state_nxt = ST_RND;
          wk_nxt    = '{a: h_r[0], b: h_r[1], c: h_r[2], d: h_r[3], e: h_r[4]};
        end
      end

      ST_RND: begin
        win_ctl.word_en = 1'b1;
        wk_nxt          = wk_round;
        if (rnd_r == RndLast) begin
          rnd_nxt   = 7'd0;
          state_nxt = ST_ADD;
        end else begin
          rnd_nxt = rnd_r + 7'd1;
        end
      end

      ST_ADD: begin
        h_nxt[0] = h_r[0] + wk_r.a;
        h_nxt[1] = h_r[1] + wk_r.b;
        h_nxt[2] = h_r[2] + wk_r.c;
        h_nxt[3] = h_r[3] + wk_r.d;
        h_nxt[4] = h_r[4] + wk_r.e;
        if (!fin_r) begin
          state_nxt = ST_IDLE;
        end else if (!seen80_r) begin
          state_nxt = ST_PAD;
        end else if (!lenblk_r) begin
          lenblk_nxt = 1'b1;
          state_nxt  = ST_PAD;
        end else begin
          idx_nxt   = 3'd0;
          state_nxt = ST_OUT;
        end
      end

      ST_OUT: begin
        if (out_xfer) begin
          if (idx_r == IdxLast) begin
            idx_nxt   = 3'd0;
            h_nxt     = HInit;
            bits_nxt  = 64'd0;
            fill_nxt  = 6'd0;
            fin_nxt   = 1'b0;
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt = idx_r + 3'd1;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control and chaining registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      fill_r   <= 6'd0;
      bits_r   <= 64'd0;
      fin_r    <= 1'b0;
      seen80_r <= 1'b0;
      lenblk_r <= 1'b0;
      rnd_r    <= 7'd0;
      idx_r    <= 3'd0;
      h_r      <= HInit;
    end else begin
      state_r  <= state_nxt;
      fill_r   <= fill_nxt;
      bits_r   <= bits_nxt;
      fin_r    <= fin_nxt;
      seen80_r <= seen80_nxt;
      lenblk_r <= lenblk_nxt;
      rnd_r    <= rnd_nxt;
      idx_r    <= idx_nxt;
      h_r      <= h_nxt;
    end
  end

  // Working variables need no reset.
  always_ff @(posedge clk) begin
    wk_r <= wk_nxt;
  end

  // Checks on the sequencer.
  `ASSERT_IMPLY(a_idx_range, state_r == ST_OUT, idx_r <= IdxLast, "word index out of range")
  `ASSERT_IMPLY(a_rnd_rest, state_r != ST_RND, rnd_r == 7'd0, "round count left running")
  `ASSERT_NEXT(a_out_done, out_xfer && out_last_word,
               (state_r == ST_IDLE) && (bits_r == 64'd0) && (fill_r == 6'd0),
               "no restart after digest")
  `ASSERT_NEXT(a_pad_full, (state_r == ST_PAD) && (fill_r == FillMax), state_r == ST_RND,
               "full padded block not compressed")

endmodule

### tb/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Hash constants kept locally so the predictor stands on its own.
  localparam logic [31:0] IvWords [5] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };
  localparam logic [31:0] RoundK [4] = '{
    32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hCA62C1D6
  };
  localparam logic [7:0] PadMarker  = 8'h80;
  localparam int         LengthSlot = 56;

  // Message lengths around the padding and block boundaries.
  localparam int BoundaryLen [10] = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};

  localparam int RandomItems = 420;
  localparam int CycleLimit  = 500000;
  localparam int SettleCycles = 400;

  localparam logic [159:0] EmptyDigest = 160'hda39a3ee5e6b4b0d3255bfef95601890afd80709;
  localparam logic [159:0] AbcDigest   = 160'ha9993e364706816aba3e25717850c26c9cd0d89d;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_word_t;

  typedef struct packed {
    logic [7:0]   data;
    logic         present;
    logic         eom;
    logic         known;
    logic [159:0] digest;
  } stim_row_t;

  // Directed stimulus: idle items, empty message, a known short message,
  // the byte extremes and an end of message with and without its own byte.
  localparam int DirRows = 12;
  localparam stim_row_t DirTable [DirRows] = '{
    '{8'hFF, 1'b0, 1'b0, 1'b0, 160'h0},
    '{8'h00, 1'b0, 1'b1, 1'b1, EmptyDigest},
    '{8'h61, 1'b1, 1'b0, 1'b0, 160'h0},
    '{8'h62, 1'b1, 1'b0, 1'b0, 160'h0},
    '{8'h63, 1'b1, 1'b1, 1'b1, AbcDigest},
    '{8'h00, 1'b1, 1'b0, 1'b0, 160'h0},
    '{8'hFF, 1'b0, 1'b0, 1'b0, 160'h0},
    '{8'hFF, 1'b1, 1'b0, 1'b0, 160'h0},
    '{8'h00, 1'b0, 1'b1, 1'b0, 160'h0},
    '{8'hFF, 1'b1, 1'b1, 1'b0, 160'h0},
    '{8'h00, 1'b1, 1'b1, 1'b0, 160'h0},
    '{8'h80, 1'b0, 1'b1, 1'b1, EmptyDigest}
  };

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_data_byte;
  logic        in_byte_present;
  logic        in_end_of_message;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_digest_word;
  logic [2:0]  out_word_index;
  logic        out_last_word;

  // Predictor state.
  logic [31:0] hash_h [5];
  logic [7:0]  blk_bytes [64];
  int          blk_fill;
  logic [63:0] msg_bit_count;

  digest_word_t digest_words_due [$];

  int unsigned send_gap_pct;
  int unsigned recv_stall_pct;
  int          error_count;
  int          words_checked;
  int          messages_done;
  int          items_taken;
  int          cycle_count;

  sha1_message_digest uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .in_byte_present  (in_byte_present),
    .in_end_of_message(in_end_of_message),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_digest_word  (out_digest_word),
    .out_word_index   (out_word_index),
    .out_last_word    (out_last_word)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("sha1_message_digest regression: fail");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  // One 80-round compression of the gathered block into the chaining words.
  function automatic void sha1_compress();
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, e, f, kc, t, x;
    int s;
    for (int r = 0; r < 16; r++) begin
      w[r] = {blk_bytes[4*r], blk_bytes[4*r+1], blk_bytes[4*r+2], blk_bytes[4*r+3]};
    end
    a = hash_h[0];
    b = hash_h[1];
    c = hash_h[2];
    d = hash_h[3];
    e = hash_h[4];
    for (int r = 0; r < 80; r++) begin
      s = r % 16;
      if (r >= 16) begin
        x = w[(r + 13) % 16] ^ w[(r + 8) % 16] ^ w[(r + 2) % 16] ^ w[s];
        w[s] = {x[30:0], x[31]};
      end
      if (r < 20) begin
        f = (b & c) | (~b & d);
      end else if (r < 40) begin
        f = b ^ c ^ d;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d);
      end else begin
        f = b ^ c ^ d;
      end
      kc = RoundK[r / 20];
      t = {a[26:0], a[31:27]} + f + e + kc + w[s];
      e = d;
      d = c;
      c = {b[1:0], b[31:2]};
      b = a;
      a = t;
    end
    hash_h[0] += a;
    hash_h[1] += b;
    hash_h[2] += c;
    hash_h[3] += d;
    hash_h[4] += e;
  endfunction

  function automatic void digest_restart();
    for (int k = 0; k < 5; k++) hash_h[k] = IvWords[k];
    blk_fill = 0;
    msg_bit_count = '0;
  endfunction

  // Advance the predictor by one accepted transfer and queue any digest words.
  function automatic void digest_take_item(input logic [7:0] data, input logic present,
                                           input logic eom, input logic known,
                                           input logic [159:0] known_digest);
    digest_word_t dw;
    logic [159:0] dg;
    int pos;
    if (present) begin
      blk_bytes[blk_fill] = data;
      blk_fill++;
      msg_bit_count += 64'd8;
      if (blk_fill == 64) begin
        sha1_compress();
        blk_fill = 0;
      end
    end
    if (eom) begin
      // Padding: marker byte, zeros, then the big-endian bit count.
      pos = blk_fill;
      blk_bytes[pos] = PadMarker;
      pos++;
      if (pos > LengthSlot) begin
        for (int k = pos; k < 64; k++) blk_bytes[k] = 8'h00;
        sha1_compress();
        pos = 0;
      end
      for (int k = pos; k < LengthSlot; k++) blk_bytes[k] = 8'h00;
      for (int k = 0; k < 8; k++) blk_bytes[LengthSlot + k] = msg_bit_count[63 - 8*k -: 8];
      sha1_compress();
      dg = known ? known_digest : {hash_h[0], hash_h[1], hash_h[2], hash_h[3], hash_h[4]};
      for (int k = 0; k < 5; k++) begin
        dw.word = dg[159 - 32*k -: 32];
        dw.idx  = 3'(k);
        dw.last = (k == 4);
        digest_words_due.push_back(dw);
      end
      messages_done++;
      digest_restart();
    end
  endfunction

  // Offer one item from a falling edge and hold it until the transfer.
  task automatic send_item(input logic [7:0] data, input logic present, input logic eom,
                           input logic known, input logic [159:0] known_digest);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid          <= 1'b1;
    in_data_byte      <= data;
    in_byte_present   <= present;
    in_end_of_message <= eom;
    do @(posedge clk); while (in_stall);
    items_taken++;
    digest_take_item(data, present, eom, known, known_digest);
    @(negedge clk);
  endtask

  // One well-formed message with random content and occasional ignored items.
  task automatic send_message(inout int counted);
    int len;
    logic eom_on_byte;
    logic [7:0] data;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: len = $urandom_range(0, 8);
      5, 6, 7:       len = BoundaryLen[$urandom_range(0, 9)];
      default:       len = $urandom_range(0, 130);
    endcase
    eom_on_byte = (len > 0) && ($urandom_range(0, 1) == 1);
    for (int k = 0; k < len; k++) begin
      if ($urandom_range(0, 19) == 0) begin
        send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0, '0);
      end
      data = 8'($urandom_range(0, 255));
      send_item(data, 1'b1, eom_on_byte && (k == len - 1), 1'b0, '0);
      counted++;
    end
    if (!eom_on_byte) begin
      send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b0, '0);
      counted++;
    end
  endtask

  // Receiver back-pressure.
  always @(negedge clk) begin
    out_stall <= rst_n && ($urandom_range(0, 99) < recv_stall_pct);
  end

  // Compare each digest word transfer with the oldest expectation.
  always @(posedge clk) begin
    digest_word_t due;
    if (rst_n && out_valid && !out_stall) begin
      if (digest_words_due.size() == 0) begin
        report_mismatch($sformatf("unexpected digest word %08h index %0d",
                                  out_digest_word, out_word_index));
      end else begin
        due = digest_words_due.pop_front();
        words_checked++;
        if (out_digest_word !== due.word)
          report_mismatch($sformatf("word %0d: got %08h, want %08h",
                                    due.idx, out_digest_word, due.word));
        if (out_word_index !== due.idx)
          report_mismatch($sformatf("word index: got %0d, want %0d",
                                    out_word_index, due.idx));
        if (out_last_word !== due.last)
          report_mismatch($sformatf("last flag on word %0d: got %0b, want %0b",
                                    due.idx, out_last_word, due.last));
      end
    end
  end

  initial begin
    int counted;
    clk_init_dummy: begin end
    rst_n             = 1'b0;
    in_valid          = 1'b0;
    in_data_byte      = 8'h00;
    in_byte_present   = 1'b0;
    in_end_of_message = 1'b0;
    out_stall         = 1'b0;
    send_gap_pct      = 0;
    recv_stall_pct    = 0;
    error_count       = 0;
    words_checked     = 0;
    messages_done     = 0;
    items_taken       = 0;
    cycle_count       = 0;
    counted           = 0;
    for (int k = 0; k < 64; k++) blk_bytes[k] = 8'h00;
    digest_restart();

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed table, no idling.
    for (int i = 0; i < DirRows; i++) begin
      send_item(DirTable[i].data, DirTable[i].present, DirTable[i].eom,
                DirTable[i].known, DirTable[i].digest);
    end

    // Random messages over four idling phases; each phase ends with a full drain.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_gap_pct = 86; recv_stall_pct = 0;  end
        2: begin send_gap_pct = 0;  recv_stall_pct = 86; end
        default: begin send_gap_pct = 9; recv_stall_pct = 9; end
      endcase
      while (counted < (ph + 1) * RandomItems / 4) begin
        if ($urandom_range(0, 9) == 0) begin
          send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0, '0);
        end
        send_message(counted);
      end
      in_valid <= 1'b0;
      while (digest_words_due.size() != 0) @(posedge clk);
      @(negedge clk);
    end

    // Let any trailing work finish, then settle the verdict.
    repeat (SettleCycles) @(posedge clk);
    while (digest_words_due.size() != 0) begin
      report_mismatch($sformatf("digest word %0d never arrived",
                                digest_words_due[0].idx));
      void'(digest_words_due.pop_front());
    end

    $display("Run covered %0d messages over %0d input transfers, %0d digest words compared.",
             messages_done, items_taken, words_checked);
    $display("Idling phases: none, sender gaps, receiver stalls, both light; %0d mismatches.",
             error_count);
    if (error_count == 0) begin
      $display("sha1_message_digest regression: pass");
    end else begin
      $display("sha1_message_digest regression: fail");
    end
    $finish;
  end

endmodule
